/* rtl/urm_pkg.sv */
// ----------------------------------------------------------------------------
// urm_pkg
// shared types, register offsets, codes and the exit string of the uart
// register model
// ----------------------------------------------------------------------------
package urm_pkg;

	localparam int UNITS    = 4;
	localparam int EXIT_LEN = 8;
	localparam int UNIT_W   = (UNITS > 1) ? $clog2(UNITS) : 1;
	localparam int POS_W    = 4;

	// item kinds
	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_TICK  = 2'd2;

	// register byte offsets
	localparam logic [4:0] ADDR_DATA = 5'd0;
	localparam logic [4:0] ADDR_IER  = 5'd4;
	localparam logic [4:0] ADDR_IIR  = 5'd8;
	localparam logic [4:0] ADDR_LCR  = 5'd12;
	localparam logic [4:0] ADDR_MCR  = 5'd16;
	localparam logic [4:0] ADDR_LSR  = 5'd20;
	localparam logic [4:0] ADDR_MSR  = 5'd24;
	localparam logic [4:0] ADDR_DIV  = 5'd28;

	// line status bits
	localparam logic [6:0] LSR_DR    = 7'h01;
	localparam logic [6:0] LSR_OE    = 7'h02;
	localparam logic [6:0] LSR_THRE  = 7'h60;
	localparam logic [6:0] LSR_TEMT  = 7'h20;
	localparam logic [6:0] LSR_RESET = 7'h60;

	// interrupt enable bits
	localparam logic [3:0] IER_RX  = 4'h1;
	localparam logic [3:0] IER_TX  = 4'h2;
	localparam logic [3:0] IER_ERR = 4'h4;

	// interrupt identity codes
	localparam logic [2:0] IIR_NONE = 3'd1;
	localparam logic [2:0] IIR_ERR  = 3'd6;
	localparam logic [2:0] IIR_RX   = 3'd4;
	localparam logic [2:0] IIR_TX   = 3'd2;

	// configuration registers
	localparam logic       CFG_TX_TICKS      = 1'b0;
	localparam logic       CFG_NEWLINE       = 1'b1;
	localparam logic [15:0] TX_TICKS_RESET   = 16'd1000;
	localparam logic [7:0]  NEWLINE_RESET    = 8'd10;

	typedef logic [7:0] char_arr_t [16];

	localparam char_arr_t EXIT_CHARS = '{
		8'h23, 8'h21, 8'h65, 8'h78, 8'h69, 8'h74, 8'h21, 8'h23,
		8'h21, 8'h65, 8'h78, 8'h69, 8'h74, 8'h21, 8'h23, 8'h21
	};

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  unit;
		logic [4:0]  address;
		logic [31:0] write_data;
		logic [63:0] time_req;
		logic        rx_valid;
		logic [7:0]  rx_byte;
	} item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       irq;
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       terminate_seen;
	} result_t;

	typedef struct packed {
		logic [15:0] tx_char_ticks;
		logic [7:0]  newline_char;
	} cfg_t;

	typedef struct packed {
		logic       strobe;
		logic [7:0] rx_byte;
	} match_req_t;

	function automatic logic [7:0] exit_char_at(input logic [POS_W-1:0] pos,
		input logic [7:0] newline);
		logic [7:0] ch;
		if (({1'b0, pos} + 5'd1) >= 5'(EXIT_LEN)) begin
			ch = newline;
		end else begin
			ch = EXIT_CHARS[pos];
		end
		return ch;
	endfunction

endpackage

/* rtl/urm_cfg.sv */
// ----------------------------------------------------------------------------
// urm_cfg
// apb configuration registers: character time and exit string newline
// ----------------------------------------------------------------------------
module urm_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output urm_pkg::cfg_t       cfg
);

	logic [15:0] tx_char_ticks_q;
	logic [7:0]  newline_char_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_char_ticks_q <= urm_pkg::TX_TICKS_RESET;
			newline_char_q  <= urm_pkg::NEWLINE_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				urm_pkg::CFG_TX_TICKS: tx_char_ticks_q <= pwdata[15:0];
				urm_pkg::CFG_NEWLINE:  newline_char_q  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			urm_pkg::CFG_TX_TICKS: prdata = {16'd0, tx_char_ticks_q};
			urm_pkg::CFG_NEWLINE:  prdata = {24'd0, newline_char_q};
			default:               prdata = 32'd0;
		endcase
	end

	assign cfg.tx_char_ticks = tx_char_ticks_q;
	assign cfg.newline_char  = newline_char_q;

endmodule

/* rtl/urm_match.sv */
// ----------------------------------------------------------------------------
// urm_match
// shared exit string matcher fed by received bytes of all units
// ----------------------------------------------------------------------------
module urm_match (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic [7:0]          newline_char,
	input  urm_pkg::match_req_t req,
	output logic                terminate_seen
);

	logic [urm_pkg::POS_W-1:0] pos_q;
	logic [urm_pkg::POS_W-1:0] pos_nxt;
	logic [urm_pkg::POS_W:0]   pos_inc;

	assign pos_inc = {1'b0, pos_q} + 1'b1;

	always_comb begin
		pos_nxt        = pos_q;
		terminate_seen = 1'b0;
		if (req.strobe) begin
			if (req.rx_byte == urm_pkg::exit_char_at(pos_q, newline_char)) begin
				if (pos_inc >= (urm_pkg::POS_W+1)'(urm_pkg::EXIT_LEN)) begin
					terminate_seen = 1'b1;
					pos_nxt        = '0;
				end else begin
					pos_nxt = pos_inc[urm_pkg::POS_W-1:0];
				end
			end else if (req.rx_byte ==
				urm_pkg::exit_char_at('0, newline_char)) begin
				pos_nxt = urm_pkg::POS_W'(1);
			end else begin
				pos_nxt = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (advance) begin
			pos_q <= pos_nxt;
		end
	end

endmodule

/* rtl/urm_units.sv */
// ----------------------------------------------------------------------------
// urm_units
// per-unit register file with write, read and tick handling
// ----------------------------------------------------------------------------
module urm_units (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  urm_pkg::item_t      item,
	input  logic [15:0]         tx_char_ticks,
	output logic [7:0]          read_data,
	output logic                irq,
	output logic                tx_valid,
	output logic [7:0]          tx_byte,
	output urm_pkg::match_req_t match_req
);

	logic [7:0]  rx_buffer_q      [urm_pkg::UNITS];
	logic [3:0]  int_enable_q     [urm_pkg::UNITS];
	logic [6:0]  line_control_q   [urm_pkg::UNITS];
	logic [1:0]  modem_control_q  [urm_pkg::UNITS];
	logic [15:0] baud_divisor_q   [urm_pkg::UNITS];
	logic [6:0]  line_status_q    [urm_pkg::UNITS];
	logic [2:0]  int_identity_q   [urm_pkg::UNITS];
	logic [63:0] tx_start_stamp_q [urm_pkg::UNITS];

	logic [urm_pkg::UNIT_W-1:0] idx;
	logic        in_range;
	logic [6:0]  lsr_cur;
	logic [3:0]  ier_cur;
	logic [63:0] stamp_cur;
	logic [63:0] stamp_start;
	logic [63:0] deadline;
	logic        tx_done;

	logic [7:0]  rxb_nxt;
	logic [3:0]  ier_nxt;
	logic [6:0]  lcr_nxt;
	logic [1:0]  mcr_nxt;
	logic [15:0] div_nxt;
	logic [6:0]  lsr_nxt;
	logic [2:0]  iir_nxt;
	logic [63:0] stamp_nxt;

	assign idx      = urm_pkg::UNIT_W'(item.unit);
	assign in_range = {30'd0, item.unit} < 32'(urm_pkg::UNITS);
	assign lsr_cur  = line_status_q[idx];
	assign ier_cur  = int_enable_q[idx];
	assign stamp_cur = tx_start_stamp_q[idx];

	assign stamp_start = (((lsr_cur & urm_pkg::LSR_THRE) == 7'd0) && (stamp_cur == 64'd0)) ?
		item.time_req : stamp_cur;
	assign deadline = stamp_start + {48'd0, tx_char_ticks};
	assign tx_done  = item.time_req >= deadline;

	always_comb begin
		rxb_nxt   = rx_buffer_q[idx];
		ier_nxt   = ier_cur;
		lcr_nxt   = line_control_q[idx];
		mcr_nxt   = modem_control_q[idx];
		div_nxt   = baud_divisor_q[idx];
		lsr_nxt   = lsr_cur;
		iir_nxt   = int_identity_q[idx];
		stamp_nxt = stamp_cur;
		read_data = 8'd0;
		irq       = 1'b0;
		tx_valid  = 1'b0;
		tx_byte   = 8'd0;
		match_req.strobe  = 1'b0;
		match_req.rx_byte = item.rx_byte;
		if (in_range) begin
			case (item.kind)
				urm_pkg::KIND_WRITE: begin
					case (item.address)
						urm_pkg::ADDR_DATA: begin
							tx_valid = 1'b1;
							tx_byte  = item.write_data[7:0];
							lsr_nxt  = lsr_cur & ~urm_pkg::LSR_THRE;
						end
						urm_pkg::ADDR_IER: ier_nxt = item.write_data[3:0];
						urm_pkg::ADDR_LCR: lcr_nxt = item.write_data[6:0];
						urm_pkg::ADDR_MCR: mcr_nxt = item.write_data[1:0];
						urm_pkg::ADDR_DIV: div_nxt = item.write_data[15:0];
						default: ;
					endcase
				end
				urm_pkg::KIND_READ: begin
					case (item.address)
						urm_pkg::ADDR_DATA: begin
							read_data = rx_buffer_q[idx];
							lsr_nxt   = lsr_cur & ~urm_pkg::LSR_DR;
						end
						urm_pkg::ADDR_IIR: read_data = {5'd0, int_identity_q[idx]};
						urm_pkg::ADDR_LSR: read_data = {1'b0, lsr_cur};
						urm_pkg::ADDR_MSR: read_data = 8'd0;
						default: ;
					endcase
				end
				urm_pkg::KIND_TICK: begin
					stamp_nxt = tx_done ? 64'd0 : stamp_start;
					lsr_nxt   = lsr_cur | (tx_done ? urm_pkg::LSR_THRE : 7'd0);
					if (item.rx_valid) begin
						rxb_nxt          = item.rx_byte;
						lsr_nxt          = lsr_nxt | urm_pkg::LSR_DR;
						match_req.strobe = 1'b1;
					end
					iir_nxt = urm_pkg::IIR_NONE;
					if (((lsr_nxt & urm_pkg::LSR_OE) != 7'd0) &&
						((ier_cur & urm_pkg::IER_ERR) != 4'd0)) begin
						irq     = 1'b1;
						iir_nxt = urm_pkg::IIR_ERR;
					end else if (((lsr_nxt & urm_pkg::LSR_DR) != 7'd0) &&
						((ier_cur & urm_pkg::IER_RX) != 4'd0)) begin
						irq     = 1'b1;
						iir_nxt = urm_pkg::IIR_RX;
					end else if (((lsr_nxt & urm_pkg::LSR_TEMT) != 7'd0) &&
						((ier_cur & urm_pkg::IER_TX) != 4'd0)) begin
						irq     = 1'b1;
						iir_nxt = urm_pkg::IIR_TX;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < urm_pkg::UNITS; i++) begin
				rx_buffer_q[i]      <= 8'd0;
				int_enable_q[i]     <= 4'd0;
				line_control_q[i]   <= 7'd0;
				modem_control_q[i]  <= 2'd0;
				baud_divisor_q[i]   <= 16'd0;
				line_status_q[i]    <= urm_pkg::LSR_RESET;
				int_identity_q[i]   <= 3'd0;
				tx_start_stamp_q[i] <= 64'd0;
			end
		end else if (advance && in_range) begin
			rx_buffer_q[idx]      <= rxb_nxt;
			int_enable_q[idx]     <= ier_nxt;
			line_control_q[idx]   <= lcr_nxt;
			modem_control_q[idx]  <= mcr_nxt;
			baud_divisor_q[idx]   <= div_nxt;
			line_status_q[idx]    <= lsr_nxt;
			int_identity_q[idx]   <= iir_nxt;
			tx_start_stamp_q[idx] <= stamp_nxt;
		end
	end

endmodule

/* rtl/uart_register_model_core.sv */
// ----------------------------------------------------------------------------
// uart_register_model_core
// 16550-style register model for several uart units with a shared exit
// string matcher
// ----------------------------------------------------------------------------
// Each word (register write, register read or time tick) is captured in an
// input register and fully processed against the per-unit registers, giving
// one result word per input word. A new word is taken every cycle unless
// in_stall holds it; the longest path is the 64-bit start stamp add and
// compare of a tick. The result register lets the next word be taken while
// a result waits under stall. The user must write configuration (character
// time, exit newline) over apb only while the block is idle, unenforced.
module uart_register_model_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [1:0]  unit,
	input  logic [4:0]  address,
	input  logic [31:0] write_data,
	input  logic [63:0] time_req,
	input  logic        rx_valid,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  read_data,
	output logic        irq,
	output logic        tx_valid,
	output logic [7:0]  tx_byte,
	output logic        terminate_seen
);

	urm_pkg::cfg_t       cfg;
	urm_pkg::item_t      item_s1;
	urm_pkg::result_t    result_q;
	urm_pkg::result_t    result_nxt;
	urm_pkg::match_req_t match_req;
	logic                valid_s1;
	logic                out_valid_q;
	logic                advance;
	logic                accept;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	urm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	urm_units u_units (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.item          (item_s1),
		.tx_char_ticks (cfg.tx_char_ticks),
		.read_data     (result_nxt.read_data),
		.irq           (result_nxt.irq),
		.tx_valid      (result_nxt.tx_valid),
		.tx_byte       (result_nxt.tx_byte),
		.match_req     (match_req)
	);

	urm_match u_match (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (advance),
		.newline_char   (cfg.newline_char),
		.req            (match_req),
		.terminate_seen (result_nxt.terminate_seen)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.kind       <= kind;
			item_s1.unit       <= unit;
			item_s1.address    <= address;
			item_s1.write_data <= write_data;
			item_s1.time_req   <= time_req;
			item_s1.rx_valid   <= rx_valid;
			item_s1.rx_byte    <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_nxt;
		end
	end

	assign out_valid      = out_valid_q;
	assign read_data      = result_q.read_data;
	assign irq            = result_q.irq;
	assign tx_valid       = result_q.tx_valid;
	assign tx_byte        = result_q.tx_byte;
	assign terminate_seen = result_q.terminate_seen;

endmodule
